FILE: hdl/shd_pkg.sv
package shd_pkg;

  localparam int CMD_W    = 2;
  localparam int SYM_IN_W = 8;
  localparam int IDX_W    = 8;
  localparam int CFG_W    = 9;
  localparam int DIST_W   = 9;
  localparam int WS_W     = 32;

  localparam logic [CMD_W-1:0] CMD_PATTERN = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TEXT    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;

  localparam logic [DIST_W-1:0] DIST_SAT = 9'd511;

  typedef struct packed {
    logic wr;
    logic step;
  } cell_ctl_t;

endpackage

FILE: hdl/shd_in_if.sv
interface shd_in_if;
  import shd_pkg::*;

  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    cmd;
  logic [SYM_IN_W-1:0] symbol;
  logic [IDX_W-1:0]    pattern_index;

  modport source (output valid, output cmd, output symbol, output pattern_index, input ready);
  modport sink (input valid, input cmd, input symbol, input pattern_index, output ready);
endinterface

FILE: hdl/shd_out_if.sv
interface shd_out_if;
  import shd_pkg::*;

  logic              valid;
  logic              ready;
  logic [DIST_W-1:0] distance;
  logic [WS_W-1:0]   window_start;

  modport source (output valid, output distance, output window_start, input ready);
  modport sink (input valid, input distance, input window_start, output ready);
endinterface

FILE: hdl/shd_cell.sv
module shd_cell #(
  parameter int SYMBOL_BITS = 8,
  parameter int SUM_W       = 9
) (
  input  logic                   clk,
  input  shd_pkg::cell_ctl_t     ctl,
  input  logic [SYMBOL_BITS-1:0] bcast,
  input  logic [SYMBOL_BITS-1:0] text_in,
  input  logic [SUM_W-1:0]       sum_in,
  output logic [SYMBOL_BITS-1:0] text_out,
  output logic [SUM_W-1:0]       sum_out
);
  import shd_pkg::*;

  logic [SYMBOL_BITS-1:0] pat_r;
  logic [SYMBOL_BITS-1:0] text_r;
  logic [SUM_W-1:0]       sum_r;

  // Each step adds this cell's mismatch to the partial sum handed over by its neighbor.
  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      pat_r <= bcast;
    end
    if (ctl.step) begin
      text_r <= text_in;
      sum_r  <= sum_in + SUM_W'(pat_r != bcast);
    end
  end

  assign text_out = text_r;
  assign sum_out  = sum_r;
endmodule

FILE: hdl/sliding_hamming_distance.sv
// Sliding Hamming distance between a stored pattern and a text stream. A row of
// PATTERN_MAX cells holds the pattern, the most recent text symbols and running
// partial sums that move one cell along at each text step, so after a text step
// cell j holds the distance for a window of length j+1 ending at the newest symbol.
// A pattern write or a restart request leaves the block idle. A text request steps
// the row; once the window holds the configured length (cfg_len_r, 0 read as 1,
// clamped to PATTERN_MAX), a select state then registers that cell's partial sum,
// waiting while the output register is full. If the pattern was written since the
// last text request, the row first replays its stored text window through the
// cells. A request is taken while an earlier result waits in the output register.
module sliding_hamming_distance #(
  parameter int PATTERN_MAX = 256,
  parameter int SYMBOL_BITS = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [shd_pkg::CFG_W-1:0]  cfg_wdata,
  shd_in_if.sink                     in_chan,
  shd_out_if.source                  out_chan
);
  import shd_pkg::*;

  localparam int LW = $clog2(PATTERN_MAX + 1);
  localparam int CW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int EW = (LW > DIST_W) ? LW : DIST_W;
  localparam logic [SYM_IN_W-1:0] SYM_MASK = SYM_IN_W'((64'd1 << SYMBOL_BITS) - 64'd1);

  typedef enum logic [1:0] {ST_IDLE, ST_REPLAY, ST_SHIFT, ST_RESULT} state_t;

  state_t                 state_r;
  logic                   dirty_r;
  logic                   want_r;
  logic [CW-1:0]          cnt_r;
  logic [WS_W-1:0]        text_count_r;
  logic [LW-1:0]          fill_r;
  logic [CFG_W-1:0]       cfg_len_r;
  logic [SYMBOL_BITS-1:0] sym_r;
  logic [WS_W-1:0]        ws_r;
  logic                   out_valid_r;
  logic [DIST_W-1:0]      out_dist_r;
  logic [WS_W-1:0]        out_ws_r;

  logic                   in_acc;
  logic [SYMBOL_BITS-1:0] sym_m;
  logic [LW-1:0]          len_eff;
  logic [LW-1:0]          fill_nxt;
  logic [WS_W-1:0]        count_nxt;
  logic                   idx_ok;
  logic                   step;
  logic [SYMBOL_BITS-1:0] bcast;
  logic [LW-1:0]          sel_sum;
  logic [EW-1:0]          sel_ext;
  logic [DIST_W-1:0]      dist_sat;

  cell_ctl_t              ctl   [PATTERN_MAX];
  logic [SYMBOL_BITS-1:0] text_q [PATTERN_MAX];
  logic [LW-1:0]          sum_q  [PATTERN_MAX];

  assign in_acc    = in_chan.valid && in_chan.ready;
  assign sym_m     = SYMBOL_BITS'(in_chan.symbol & SYM_MASK);
  assign idx_ok    = 32'(in_chan.pattern_index) < 32'(PATTERN_MAX);
  assign count_nxt = text_count_r + 32'd1;
  assign fill_nxt  = (fill_r == LW'(PATTERN_MAX)) ? fill_r : fill_r + LW'(1);

  always_comb begin
    if (cfg_len_r == '0) begin
      len_eff = LW'(1);
    end else if (32'(cfg_len_r) > 32'(PATTERN_MAX)) begin
      len_eff = LW'(PATTERN_MAX);
    end else begin
      len_eff = LW'(cfg_len_r);
    end
  end

  assign step = (state_r == ST_REPLAY) || (state_r == ST_SHIFT) ||
                ((state_r == ST_IDLE) && in_acc && (in_chan.cmd == CMD_TEXT) && !dirty_r);

  always_comb begin
    case (state_r)
      ST_REPLAY: bcast = text_q[PATTERN_MAX-1];
      ST_SHIFT:  bcast = sym_r;
      default:   bcast = sym_m;
    endcase
  end

  for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cell
    assign ctl[j].step = step;
    assign ctl[j].wr   = (state_r == ST_IDLE) && in_acc && (in_chan.cmd == CMD_PATTERN) &&
                         (32'(in_chan.pattern_index) == j);

    if (j == 0) begin : g_head
      shd_cell #(.SYMBOL_BITS(SYMBOL_BITS), .SUM_W(LW)) u_cell (
        .clk      (clk),
        .ctl      (ctl[j]),
        .bcast    (bcast),
        .text_in  (bcast),
        .sum_in   ('0),
        .text_out (text_q[j]),
        .sum_out  (sum_q[j])
      );
    end else begin : g_body
      shd_cell #(.SYMBOL_BITS(SYMBOL_BITS), .SUM_W(LW)) u_cell (
        .clk      (clk),
        .ctl      (ctl[j]),
        .bcast    (bcast),
        .text_in  (text_q[j-1]),
        .sum_in   (sum_q[j-1]),
        .text_out (text_q[j]),
        .sum_out  (sum_q[j])
      );
    end
  end

  always_comb begin
    sel_sum = '0;
    for (int j = 0; j < PATTERN_MAX; j++) begin
      sel_sum = sel_sum | (sum_q[j] & {LW{len_eff == LW'(j + 1)}});
    end
  end

  assign sel_ext  = EW'(sel_sum);
  assign dist_sat = (sel_ext > EW'(DIST_SAT)) ? DIST_SAT : DIST_W'(sel_ext);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      dirty_r      <= 1'b0;
      want_r       <= 1'b0;
      cnt_r        <= '0;
      text_count_r <= '0;
      fill_r       <= '0;
      cfg_len_r    <= CFG_W'(1);
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        cfg_len_r <= cfg_wdata;
      end
      if (out_chan.ready && (state_r != ST_RESULT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            case (in_chan.cmd)
              CMD_PATTERN: begin
                if (idx_ok) begin
                  dirty_r <= 1'b1;
                end
              end
              CMD_TEXT: begin
                text_count_r <= count_nxt;
                fill_r       <= fill_nxt;
                want_r       <= fill_nxt >= len_eff;
                ws_r         <= count_nxt - WS_W'(len_eff);
                sym_r        <= sym_m;
                if (dirty_r) begin
                  cnt_r   <= '0;
                  state_r <= ST_REPLAY;
                end else if (fill_nxt >= len_eff) begin
                  state_r <= ST_RESULT;
                end
              end
              CMD_RESTART: begin
                text_count_r <= '0;
                fill_r       <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        ST_REPLAY: begin
          cnt_r <= cnt_r + CW'(1);
          if (cnt_r == CW'(PATTERN_MAX - 1)) begin
            state_r <= ST_SHIFT;
          end
        end
        ST_SHIFT: begin
          dirty_r <= 1'b0;
          state_r <= want_r ? ST_RESULT : ST_IDLE;
        end
        ST_RESULT: begin
          if (!out_valid_r || out_chan.ready) begin
            out_valid_r <= 1'b1;
            out_dist_r  <= dist_sat;
            out_ws_r    <= ws_r;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_chan.ready         = (state_r == ST_IDLE);
  assign out_chan.valid        = out_valid_r;
  assign out_chan.distance     = out_dist_r;
  assign out_chan.window_start = out_ws_r;

  a_result_from_select: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_RESULT)
    else $error("Result appeared without a select cycle.");

  a_replay_clears_dirty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SHIFT |=> !dirty_r)
    else $error("Pattern still marked changed after replay.");

  a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_chan.cmd == CMD_RESTART) |=> (fill_r == '0) && (text_count_r == '0))
    else $error("Restart did not clear the window count.");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_chan.cmd == CMD_TEXT) |=> fill_r <= LW'(PATTERN_MAX))
    else $error("Fill count exceeded the pattern depth.");

endmodule
